FILE: design/quad8_shape_function_eval_defines.svh
// ----------------------------------------------------------------------------
// quad8 shape function evaluator: assertion macros
// Shared concurrent assertion forms for the design modules.
// ----------------------------------------------------------------------------
`ifndef QUAD8_SHAPE_FUNCTION_EVAL_DEFINES_SVH
`define QUAD8_SHAPE_FUNCTION_EVAL_DEFINES_SVH

// consequent checked in the same cycle
`define Q8SF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the next cycle
`define Q8SF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/q8sf_pkg.sv
// ----------------------------------------------------------------------------
// q8sf_pkg
// Types, constants and width helpers shared by the quad8 shape function
// evaluator modules.
// ----------------------------------------------------------------------------
package q8sf_pkg;

   // fixed field widths
   localparam int COORD_BITS    = 16;
   localparam int NODE_BITS     = 3;
   localparam int FRAC_BITS_DEF = 14;

   // saturation limits of a 16-bit result field
   localparam int SAT_MAX = 32767;
   localparam int SAT_MIN = -32768;

   // wide scratch width for the truncate and saturate helper
   localparam int WIDE_BITS  = 128;
   localparam int SHAMT_BITS = $clog2(WIDE_BITS);

   typedef logic signed [WIDE_BITS-1:0]  wide_type;
   typedef logic        [SHAMT_BITS-1:0] shamt_type;
   typedef logic signed [COORD_BITS-1:0] field_type;

   // node numbering: corners then midsides
   typedef enum logic [NODE_BITS-1:0] {
      NODE_SW,
      NODE_SE,
      NODE_NE,
      NODE_NW,
      NODE_MID_S,
      NODE_MID_E,
      NODE_MID_N,
      NODE_MID_W
   } node_type;

   // offset applied to a product: p, -p, p - 1.0^2, 1.0^2 - p
   typedef enum logic [1:0] {
      OFS_PASS,
      OFS_NEG,
      OFS_LESS_ONE,
      OFS_ONE_LESS
   } ofs_type;

   // scale-back amount: frac, frac + 1, frac + 2 bits
   typedef enum logic [1:0] {
      SH_F0,
      SH_F1,
      SH_F2
   } shift_type;

   // per-node control that travels down the pipeline
   typedef struct packed {
      node_type  node;
      logic      last;
      ofs_type   ofs_val;
      shift_type sh_val;
      ofs_type   ofs_dx;
      shift_type sh_dx;
      ofs_type   ofs_de;
      shift_type sh_de;
   } ctrl_type;

   // operand width: holds 1.0 +/- a coordinate and 2x +/- y sums
   function automatic int op_width(input int frac);
      return ((frac > 15) ? frac : 15) + 3;
   endfunction

   function automatic int prod_width(input int frac);
      return 2 * op_width(frac);
   endfunction

   // product plus offset by 1.0^2
   function automatic int sum_width(input int frac);
      return prod_width(frac) + 1;
   endfunction

   // first value product after scale-back
   function automatic int t_width(input int frac);
      return sum_width(frac) - frac;
   endfunction

   function automatic int fin_width(input int frac);
      return t_width(frac) + op_width(frac);
   endfunction

   // shift amount for a scale-back code
   function automatic shamt_type shift_amt(input shift_type code, input int frac);
      shamt_type amt;
      unique case (code)
         SH_F0:   amt = SHAMT_BITS'(frac);
         SH_F1:   amt = SHAMT_BITS'(frac + 1);
         SH_F2:   amt = SHAMT_BITS'(frac + 2);
         default: amt = SHAMT_BITS'(frac);
      endcase
      return amt;
   endfunction

   // divide by 2^sh rounding toward zero, then clamp to a 16-bit field
   function automatic field_type trunc_sat(input wide_type v, input shamt_type sh);
      wide_type         q;
      wide_type         hi;
      wide_type         lo;
      logic [WIDE_BITS-1:0] mask;
      field_type        r;
      hi   = WIDE_BITS'(SAT_MAX);
      lo   = WIDE_BITS'(SAT_MIN);
      mask = (WIDE_BITS'(1) << sh) - WIDE_BITS'(1);
      q    = v >>> sh;
      if (v[WIDE_BITS-1] && (|(v & mask))) begin
         q = q + WIDE_BITS'(1);
      end
      if (q > hi) begin
         r = COORD_BITS'(SAT_MAX);
      end else if (q < lo) begin
         r = COORD_BITS'(SAT_MIN);
      end else begin
         r = COORD_BITS'(q);
      end
      return r;
   endfunction

endpackage

FILE: design/q8sf_issue.sv
// ----------------------------------------------------------------------------
// q8sf_issue
// Takes a coordinate request, then walks the eight nodes one per cycle when
// not stalled, registering multiplier operands and control for each node.
// ----------------------------------------------------------------------------
`include "quad8_shape_function_eval_defines.svh"

module q8sf_issue #(
   parameter  int FRAC_BITS = q8sf_pkg::FRAC_BITS_DEF,
   localparam int OPW       = q8sf_pkg::op_width(FRAC_BITS)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [q8sf_pkg::COORD_BITS-1:0] req_xi_coord,
   input  logic signed [q8sf_pkg::COORD_BITS-1:0] req_eta_coord,
   output logic                                 op_valid,
   input  logic                                 op_ready,
   output logic signed [OPW-1:0]                op_a1,
   output logic signed [OPW-1:0]                op_b1,
   output logic signed [OPW-1:0]                op_c1,
   output logic signed [OPW-1:0]                op_a2,
   output logic signed [OPW-1:0]                op_b2,
   output logic signed [OPW-1:0]                op_a3,
   output logic signed [OPW-1:0]                op_b3,
   output q8sf_pkg::ctrl_type                   op_ctrl
);

   localparam logic signed [OPW-1:0] ONE = OPW'(1) << FRAC_BITS;

   logic                                   busy_ff, busy_in;
   q8sf_pkg::node_type                     node_ff, node_in;
   logic signed [q8sf_pkg::COORD_BITS-1:0] x_ff, x_in, e_ff, e_in;
   logic                                   op_valid_ff;
   logic signed [OPW-1:0]                  a1_ff, b1_ff, c1_ff, a2_ff, b2_ff, a3_ff, b3_ff;
   logic signed [OPW-1:0]                  a1_in, b1_in, c1_in, a2_in, b2_in, a3_in, b3_in;
   q8sf_pkg::ctrl_type                     ctrl_ff, ctrl_in;

   logic                  slot_ready, emit, last_emit, accept;
   logic signed [OPW-1:0] xs, es, xm, xp, em, ep;
   logic signed [OPW-1:0] x2e_p, x2e_m, e2x_p, e2x_m, xm1, em1;
   logic signed [OPW-1:0] c_sw, c_se, c_ne, c_nw;

   // sequencer handshake
   assign slot_ready = !op_valid_ff || op_ready;
   assign emit       = busy_ff && slot_ready;
   assign last_emit  = emit && (node_ff == q8sf_pkg::NODE_MID_W);
   assign req_ready  = !busy_ff || last_emit;
   assign accept     = req_valid && req_ready;

   always_comb begin
      busy_in = busy_ff;
      node_in = node_ff;
      x_in    = x_ff;
      e_in    = e_ff;
      if (accept) begin
         busy_in = 1'b1;
         node_in = q8sf_pkg::NODE_SW;
         x_in    = req_xi_coord;
         e_in    = req_eta_coord;
      end else if (emit) begin
         busy_in = !last_emit;
         node_in = q8sf_pkg::node_type'(node_ff + 1'b1);
      end
   end

   // common sums of the coordinates
   assign xs    = OPW'(x_ff);
   assign es    = OPW'(e_ff);
   assign xm    = ONE - xs;
   assign xp    = ONE + xs;
   assign em    = ONE - es;
   assign ep    = ONE + es;
   assign x2e_p = xs + xs + es;
   assign x2e_m = xs + xs - es;
   assign e2x_p = es + es + xs;
   assign e2x_m = es + es - xs;
   assign xm1   = xs - ONE;
   assign em1   = es - ONE;
   assign c_sw  = -xs - es - ONE;
   assign c_se  = xs - es - ONE;
   assign c_ne  = xs + es - ONE;
   assign c_nw  = es - xs - ONE;

   // operand table per node
   always_comb begin
      a1_in           = xm;
      b1_in           = em;
      c1_in           = c_sw;
      a2_in           = em;
      b2_in           = x2e_p;
      a3_in           = xm;
      b3_in           = e2x_p;
      ctrl_in.node    = node_ff;
      ctrl_in.last    = (node_ff == q8sf_pkg::NODE_MID_W);
      ctrl_in.ofs_val = q8sf_pkg::OFS_PASS;
      ctrl_in.sh_val  = q8sf_pkg::SH_F2;
      ctrl_in.ofs_dx  = q8sf_pkg::OFS_PASS;
      ctrl_in.sh_dx   = q8sf_pkg::SH_F2;
      ctrl_in.ofs_de  = q8sf_pkg::OFS_PASS;
      ctrl_in.sh_de   = q8sf_pkg::SH_F2;
      unique case (node_ff)
         q8sf_pkg::NODE_SW: begin
            a1_in = xm; b1_in = em; c1_in = c_sw;
            a2_in = em; b2_in = x2e_p;
            a3_in = xm; b3_in = e2x_p;
         end
         q8sf_pkg::NODE_SE: begin
            a1_in = xp; b1_in = em; c1_in = c_se;
            a2_in = em; b2_in = x2e_m;
            a3_in = xp; b3_in = e2x_m;
         end
         q8sf_pkg::NODE_NE: begin
            a1_in = xp; b1_in = ep; c1_in = c_ne;
            a2_in = ep; b2_in = x2e_p;
            a3_in = xp; b3_in = e2x_p;
         end
         q8sf_pkg::NODE_NW: begin
            a1_in = xm; b1_in = ep; c1_in = c_nw;
            a2_in = ep; b2_in = x2e_m;
            a3_in = xm; b3_in = e2x_m;
         end
         q8sf_pkg::NODE_MID_S: begin
            a1_in = xs; b1_in = xs; c1_in = em;
            a2_in = xs; b2_in = em1;
            a3_in = xs; b3_in = xs;
            ctrl_in.ofs_val = q8sf_pkg::OFS_ONE_LESS;
            ctrl_in.sh_val  = q8sf_pkg::SH_F1;
            ctrl_in.sh_dx   = q8sf_pkg::SH_F0;
            ctrl_in.ofs_de  = q8sf_pkg::OFS_LESS_ONE;
            ctrl_in.sh_de   = q8sf_pkg::SH_F1;
         end
         q8sf_pkg::NODE_MID_E: begin
            a1_in = es; b1_in = es; c1_in = xp;
            a2_in = es; b2_in = es;
            a3_in = xp; b3_in = es;
            ctrl_in.ofs_val = q8sf_pkg::OFS_ONE_LESS;
            ctrl_in.sh_val  = q8sf_pkg::SH_F1;
            ctrl_in.ofs_dx  = q8sf_pkg::OFS_ONE_LESS;
            ctrl_in.sh_dx   = q8sf_pkg::SH_F1;
            ctrl_in.ofs_de  = q8sf_pkg::OFS_NEG;
            ctrl_in.sh_de   = q8sf_pkg::SH_F0;
         end
         q8sf_pkg::NODE_MID_N: begin
            a1_in = xs; b1_in = xs; c1_in = ep;
            a2_in = xs; b2_in = ep;
            a3_in = xs; b3_in = xs;
            ctrl_in.ofs_val = q8sf_pkg::OFS_ONE_LESS;
            ctrl_in.sh_val  = q8sf_pkg::SH_F1;
            ctrl_in.ofs_dx  = q8sf_pkg::OFS_NEG;
            ctrl_in.sh_dx   = q8sf_pkg::SH_F0;
            ctrl_in.ofs_de  = q8sf_pkg::OFS_ONE_LESS;
            ctrl_in.sh_de   = q8sf_pkg::SH_F1;
         end
         q8sf_pkg::NODE_MID_W: begin
            a1_in = es; b1_in = es; c1_in = xm;
            a2_in = es; b2_in = es;
            a3_in = xm1; b3_in = es;
            ctrl_in.ofs_val = q8sf_pkg::OFS_ONE_LESS;
            ctrl_in.sh_val  = q8sf_pkg::SH_F1;
            ctrl_in.ofs_dx  = q8sf_pkg::OFS_LESS_ONE;
            ctrl_in.sh_dx   = q8sf_pkg::SH_F1;
            ctrl_in.sh_de   = q8sf_pkg::SH_F0;
         end
      endcase
   end

   // sequencer state and operand register
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         node_ff     <= q8sf_pkg::NODE_SW;
         op_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         node_ff <= node_in;
         if (slot_ready) begin
            op_valid_ff <= busy_ff;
         end
      end
      x_ff <= x_in;
      e_ff <= e_in;
      if (slot_ready) begin
         a1_ff   <= a1_in;
         b1_ff   <= b1_in;
         c1_ff   <= c1_in;
         a2_ff   <= a2_in;
         b2_ff   <= b2_in;
         a3_ff   <= a3_in;
         b3_ff   <= b3_in;
         ctrl_ff <= ctrl_in;
      end
   end

   assign op_valid = op_valid_ff;
   assign op_a1    = a1_ff;
   assign op_b1    = b1_ff;
   assign op_c1    = c1_ff;
   assign op_a2    = a2_ff;
   assign op_b2    = b2_ff;
   assign op_a3    = a3_ff;
   assign op_b3    = b3_ff;
   assign op_ctrl  = ctrl_ff;

   `Q8SF_ASSERT_NEXT(a_accept_starts_run, clock, reset, accept, busy_ff && (node_ff == q8sf_pkg::NODE_SW), "accepted request did not start at the first node")
   `Q8SF_ASSERT_SAME(a_ready_only_at_end, clock, reset, busy_ff && req_ready, last_emit && (node_ff == q8sf_pkg::NODE_MID_W), "request taken before the last node was issued")

endmodule

FILE: design/q8sf_term.sv
// ----------------------------------------------------------------------------
// q8sf_term
// Two stages: the three operand products, then offset by 1.0^2, scale-back
// of the first value factor, and final scale and clamp of both derivatives.
// ----------------------------------------------------------------------------
module q8sf_term #(
   parameter  int FRAC_BITS = q8sf_pkg::FRAC_BITS_DEF,
   localparam int OPW       = q8sf_pkg::op_width(FRAC_BITS),
   localparam int TW        = q8sf_pkg::t_width(FRAC_BITS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   output logic                  up_ready,
   input  logic signed [OPW-1:0] up_a1,
   input  logic signed [OPW-1:0] up_b1,
   input  logic signed [OPW-1:0] up_c1,
   input  logic signed [OPW-1:0] up_a2,
   input  logic signed [OPW-1:0] up_b2,
   input  logic signed [OPW-1:0] up_a3,
   input  logic signed [OPW-1:0] up_b3,
   input  q8sf_pkg::ctrl_type    up_ctrl,
   output logic                  dn_valid,
   input  logic                  dn_ready,
   output logic signed [TW-1:0]  dn_t,
   output logic signed [OPW-1:0] dn_c,
   output q8sf_pkg::field_type   dn_dx,
   output q8sf_pkg::field_type   dn_de,
   output q8sf_pkg::ctrl_type    dn_ctrl
);

   localparam int PW = q8sf_pkg::prod_width(FRAC_BITS);
   localparam int SW = q8sf_pkg::sum_width(FRAC_BITS);
   localparam logic signed [SW-1:0] ONE_SQ = SW'(1) << (2 * FRAC_BITS);
   localparam logic signed [SW-1:0] MASK_F = (SW'(1) << FRAC_BITS) - SW'(1);

   // product plus offset
   function automatic logic signed [SW-1:0] apply_ofs(input logic signed [PW-1:0] p,
                                                      input q8sf_pkg::ofs_type m);
      logic signed [SW-1:0] pw;
      logic signed [SW-1:0] r;
      pw = SW'(p);
      unique case (m)
         q8sf_pkg::OFS_PASS:     r = pw;
         q8sf_pkg::OFS_NEG:      r = -pw;
         q8sf_pkg::OFS_LESS_ONE: r = pw - ONE_SQ;
         q8sf_pkg::OFS_ONE_LESS: r = ONE_SQ - pw;
      endcase
      return r;
   endfunction

   logic                 v2_ff, v3_ff, s2_ready, s3_ready;
   logic signed [PW-1:0] p1_ff, p2_ff, p3_ff, p1_in, p2_in, p3_in;
   logic signed [OPW-1:0] c2_ff, c3_ff;
   q8sf_pkg::ctrl_type   ctrl2_ff, ctrl3_ff;
   logic signed [SW-1:0] s1, s2, s3, s1_bias;
   logic signed [TW-1:0] t_ff, t_in;
   q8sf_pkg::field_type  dx_ff, dx_in, de_ff, de_in;

   // stage handshake
   assign s3_ready = !v3_ff || dn_ready;
   assign s2_ready = !v2_ff || s3_ready;
   assign up_ready = s2_ready;

   // operand products
   assign p1_in = PW'(up_a1) * PW'(up_b1);
   assign p2_in = PW'(up_a2) * PW'(up_b2);
   assign p3_in = PW'(up_a3) * PW'(up_b3);

   // offsets, value factor scale-back, derivative scale and clamp
   assign s1      = apply_ofs(p1_ff, ctrl2_ff.ofs_val);
   assign s2      = apply_ofs(p2_ff, ctrl2_ff.ofs_dx);
   assign s3      = apply_ofs(p3_ff, ctrl2_ff.ofs_de);
   assign s1_bias = s1[SW-1] ? MASK_F : '0;
   assign t_in    = TW'((s1 + s1_bias) >>> FRAC_BITS);
   assign dx_in   = q8sf_pkg::trunc_sat(q8sf_pkg::wide_type'(s2),
                       q8sf_pkg::shift_amt(ctrl2_ff.sh_dx, FRAC_BITS));
   assign de_in   = q8sf_pkg::trunc_sat(q8sf_pkg::wide_type'(s3),
                       q8sf_pkg::shift_amt(ctrl2_ff.sh_de, FRAC_BITS));

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (s2_ready) begin
            v2_ff <= up_valid;
         end
         if (s3_ready) begin
            v3_ff <= v2_ff;
         end
      end
      if (s2_ready) begin
         p1_ff    <= p1_in;
         p2_ff    <= p2_in;
         p3_ff    <= p3_in;
         c2_ff    <= up_c1;
         ctrl2_ff <= up_ctrl;
      end
      if (s3_ready) begin
         t_ff     <= t_in;
         dx_ff    <= dx_in;
         de_ff    <= de_in;
         c3_ff    <= c2_ff;
         ctrl3_ff <= ctrl2_ff;
      end
   end

   assign dn_valid = v3_ff;
   assign dn_t     = t_ff;
   assign dn_c     = c3_ff;
   assign dn_dx    = dx_ff;
   assign dn_de    = de_ff;
   assign dn_ctrl  = ctrl3_ff;

endmodule

FILE: design/q8sf_final.sv
// ----------------------------------------------------------------------------
// q8sf_final
// Second value product, then scale and clamp into the response register.
// ----------------------------------------------------------------------------
`include "quad8_shape_function_eval_defines.svh"

module q8sf_final #(
   parameter  int FRAC_BITS = q8sf_pkg::FRAC_BITS_DEF,
   localparam int OPW       = q8sf_pkg::op_width(FRAC_BITS),
   localparam int TW        = q8sf_pkg::t_width(FRAC_BITS)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  up_valid,
   output logic                                  up_ready,
   input  logic signed [TW-1:0]                  up_t,
   input  logic signed [OPW-1:0]                 up_c,
   input  q8sf_pkg::field_type                   up_dx,
   input  q8sf_pkg::field_type                   up_de,
   input  q8sf_pkg::ctrl_type                    up_ctrl,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [q8sf_pkg::NODE_BITS-1:0]        rsp_node_index,
   output logic signed [q8sf_pkg::COORD_BITS-1:0] rsp_shape_value,
   output logic signed [q8sf_pkg::COORD_BITS-1:0] rsp_deriv_xi,
   output logic signed [q8sf_pkg::COORD_BITS-1:0] rsp_deriv_eta,
   output logic                                  rsp_last_node
);

   localparam int P4W = q8sf_pkg::fin_width(FRAC_BITS);

   logic                  v4_ff, v5_ff, s4_ready, s5_ready;
   logic signed [P4W-1:0] p4_ff, p4_in;
   q8sf_pkg::field_type   dx4_ff, de4_ff, val5_ff, val5_in, dx5_ff, de5_ff;
   q8sf_pkg::ctrl_type    ctrl4_ff, ctrl5_ff;

   // stage handshake
   assign s5_ready = !v5_ff || rsp_ready;
   assign s4_ready = !v4_ff || s5_ready;
   assign up_ready = s4_ready;

   // third value factor, then scale and clamp
   assign p4_in   = P4W'(up_t) * P4W'(up_c);
   assign val5_in = q8sf_pkg::trunc_sat(q8sf_pkg::wide_type'(p4_ff),
                       q8sf_pkg::shift_amt(ctrl4_ff.sh_val, FRAC_BITS));

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (s4_ready) begin
            v4_ff <= up_valid;
         end
         if (s5_ready) begin
            v5_ff <= v4_ff;
         end
      end
      if (s4_ready) begin
         p4_ff    <= p4_in;
         dx4_ff   <= up_dx;
         de4_ff   <= up_de;
         ctrl4_ff <= up_ctrl;
      end
      if (s5_ready) begin
         val5_ff  <= val5_in;
         dx5_ff   <= dx4_ff;
         de5_ff   <= de4_ff;
         ctrl5_ff <= ctrl4_ff;
      end
   end

   assign rsp_valid       = v5_ff;
   assign rsp_node_index  = ctrl5_ff.node;
   assign rsp_shape_value = val5_ff;
   assign rsp_deriv_xi    = dx5_ff;
   assign rsp_deriv_eta   = de5_ff;
   assign rsp_last_node   = ctrl5_ff.last;

   `Q8SF_ASSERT_SAME(a_last_flag_node, clock, reset, rsp_valid, rsp_last_node == (ctrl5_ff.node == q8sf_pkg::NODE_MID_W), "last flag does not match the final node")

endmodule

FILE: design/quad8_shape_function_eval.sv
// ----------------------------------------------------------------------------
// quad8_shape_function_eval
// Eight-node serendipity quadrilateral shape functions and their xi and eta
// partials at one natural coordinate pair, signed fixed point.
// ----------------------------------------------------------------------------
// Each request carries one (xi, eta) pair and yields eight responses, node 0
// through 7 (corners, then midsides), with the last one flagged. A node
// sequencer issues one node per cycle, while the response side keeps up,
// into a five-stage pipeline (operands, products, offset and scale, second
// value product, scale and clamp into the response register). The next
// request is taken in the same cycle that the eighth node of the previous
// one is issued. Values are rounded toward zero and clamped to 16 bits.
module quad8_shape_function_eval #(
   parameter int FRAC_BITS = q8sf_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [q8sf_pkg::COORD_BITS-1:0] req_xi_coord,
   input  logic signed [q8sf_pkg::COORD_BITS-1:0] req_eta_coord,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [q8sf_pkg::NODE_BITS-1:0]        rsp_node_index,
   output logic signed [q8sf_pkg::COORD_BITS-1:0] rsp_shape_value,
   output logic signed [q8sf_pkg::COORD_BITS-1:0] rsp_deriv_xi,
   output logic signed [q8sf_pkg::COORD_BITS-1:0] rsp_deriv_eta,
   output logic                                  rsp_last_node
);

   localparam int OPW = q8sf_pkg::op_width(FRAC_BITS);
   localparam int TW  = q8sf_pkg::t_width(FRAC_BITS);

   logic                  op_valid, op_ready;
   logic signed [OPW-1:0] op_a1, op_b1, op_c1, op_a2, op_b2, op_a3, op_b3;
   q8sf_pkg::ctrl_type    op_ctrl;

   logic                  tm_valid, tm_ready;
   logic signed [TW-1:0]  tm_t;
   logic signed [OPW-1:0] tm_c;
   q8sf_pkg::field_type   tm_dx, tm_de;
   q8sf_pkg::ctrl_type    tm_ctrl;

   // node sequencer and operand register
   q8sf_issue #(.FRAC_BITS(FRAC_BITS)) u_issue (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_xi_coord  (req_xi_coord),
      .req_eta_coord (req_eta_coord),
      .op_valid      (op_valid),
      .op_ready      (op_ready),
      .op_a1         (op_a1),
      .op_b1         (op_b1),
      .op_c1         (op_c1),
      .op_a2         (op_a2),
      .op_b2         (op_b2),
      .op_a3         (op_a3),
      .op_b3         (op_b3),
      .op_ctrl       (op_ctrl)
   );

   // products and derivative scaling
   q8sf_term #(.FRAC_BITS(FRAC_BITS)) u_term (
      .clock    (clock),
      .reset    (reset),
      .up_valid (op_valid),
      .up_ready (op_ready),
      .up_a1    (op_a1),
      .up_b1    (op_b1),
      .up_c1    (op_c1),
      .up_a2    (op_a2),
      .up_b2    (op_b2),
      .up_a3    (op_a3),
      .up_b3    (op_b3),
      .up_ctrl  (op_ctrl),
      .dn_valid (tm_valid),
      .dn_ready (tm_ready),
      .dn_t     (tm_t),
      .dn_c     (tm_c),
      .dn_dx    (tm_dx),
      .dn_de    (tm_de),
      .dn_ctrl  (tm_ctrl)
   );

   // value product and response register
   q8sf_final #(.FRAC_BITS(FRAC_BITS)) u_final (
      .clock           (clock),
      .reset           (reset),
      .up_valid        (tm_valid),
      .up_ready        (tm_ready),
      .up_t            (tm_t),
      .up_c            (tm_c),
      .up_dx           (tm_dx),
      .up_de           (tm_de),
      .up_ctrl         (tm_ctrl),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_node_index  (rsp_node_index),
      .rsp_shape_value (rsp_shape_value),
      .rsp_deriv_xi    (rsp_deriv_xi),
      .rsp_deriv_eta   (rsp_deriv_eta),
      .rsp_last_node   (rsp_last_node)
   );

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: quad8 shape function evaluator testbench
// Sends (xi, eta) requests and checks the eight node responses of each one
// against a fixed-point model of the serendipity quad8 shape functions. A
// directed table, partly with exact node values, comes first, then random
// coordinates, with random gaps on both channels and one long response stall.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC         = q8sf_pkg::FRAC_BITS_DEF;
   localparam int RANDOM_ITEMS = 200;
   localparam int IDLE_LIMIT   = 2000;
   localparam int HOLD_AT      = 400;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 16;
   localparam int MAX_PRINTS   = 100;

   // exact node values at node points and at the center
   localparam q8sf_pkg::field_type ONE  = 16'sd16384;
   localparam q8sf_pkg::field_type ZRO  = 16'sd0;
   localparam q8sf_pkg::field_type QNEG = -16'sd4096;
   localparam q8sf_pkg::field_type HALF = 16'sd8192;

   typedef struct {
      q8sf_pkg::node_type  node;
      q8sf_pkg::field_type shape;
      q8sf_pkg::field_type dxi;
      q8sf_pkg::field_type deta;
      logic                last;
   } node_result_type;

   // pin lists node 7 down to node 0
   typedef struct packed {
      q8sf_pkg::field_type xi;
      q8sf_pkg::field_type eta;
      logic                has_pin;
      logic [7:0][15:0]    pin;
   } stim_row_type;

   localparam stim_row_type DIR_ROWS [21] = '{
      // node points, one-hot shape values
      '{-ONE, -ONE, 1'b1, {ZRO, ZRO, ZRO, ZRO, ZRO, ZRO, ZRO, ONE}},
      '{ ONE, -ONE, 1'b1, {ZRO, ZRO, ZRO, ZRO, ZRO, ZRO, ONE, ZRO}},
      '{ ONE,  ONE, 1'b1, {ZRO, ZRO, ZRO, ZRO, ZRO, ONE, ZRO, ZRO}},
      '{-ONE,  ONE, 1'b1, {ZRO, ZRO, ZRO, ZRO, ONE, ZRO, ZRO, ZRO}},
      '{ ZRO, -ONE, 1'b1, {ZRO, ZRO, ZRO, ONE, ZRO, ZRO, ZRO, ZRO}},
      '{ ONE,  ZRO, 1'b1, {ZRO, ZRO, ONE, ZRO, ZRO, ZRO, ZRO, ZRO}},
      '{ ZRO,  ONE, 1'b1, {ZRO, ONE, ZRO, ZRO, ZRO, ZRO, ZRO, ZRO}},
      '{-ONE,  ZRO, 1'b1, {ONE, ZRO, ZRO, ZRO, ZRO, ZRO, ZRO, ZRO}},
      // center: corners -1/4, midsides 1/2
      '{ ZRO,  ZRO, 1'b1, {HALF, HALF, HALF, HALF, QNEG, QNEG, QNEG, QNEG}},
      // outside the element, saturating values
      '{16'sd32767, 16'sd32767, 1'b0, '0},
      '{16'sh8000, 16'sh8000, 1'b0, '0},
      '{16'sd32767, 16'sh8000, 1'b0, '0},
      '{16'sh8000, 16'sd32767, 1'b0, '0},
      '{16'sd16384, 16'sh8000, 1'b0, '0},
      // smallest steps and inner points
      '{16'sd1, -16'sd1, 1'b0, '0},
      '{-16'sd1, 16'sd1, 1'b0, '0},
      '{16'sd8192, -16'sd8192, 1'b0, '0},
      '{-16'sd16383, 16'sd16383, 1'b0, '0},
      // alternating bit patterns and an arbitrary point
      '{16'sh5555, 16'shAAAA, 1'b0, '0},
      '{16'shAAAA, 16'sh5555, 1'b0, '0},
      '{16'sd12345, -16'sd6789, 1'b0, '0}
   };

   logic                           clock         = 1'b0;
   logic                           reset         = 1'b1;
   logic                           req_valid     = 1'b0;
   logic                           req_ready;
   q8sf_pkg::field_type            req_xi_coord  = '0;
   q8sf_pkg::field_type            req_eta_coord = '0;
   logic                           rsp_valid;
   logic                           rsp_ready     = 1'b0;
   logic [q8sf_pkg::NODE_BITS-1:0] rsp_node_index;
   q8sf_pkg::field_type            rsp_shape_value;
   q8sf_pkg::field_type            rsp_deriv_xi;
   q8sf_pkg::field_type            rsp_deriv_eta;
   logic                           rsp_last_node;

   node_result_type node_expect_q [$];
   int              mismatch_count = 0;
   int              idle_cycles    = 0;
   bit              req_gaps_on    = 1'b1;

   quad8_shape_function_eval #(
      .FRAC_BITS(FRAC)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_xi_coord   (req_xi_coord),
      .req_eta_coord  (req_eta_coord),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_node_index (rsp_node_index),
      .rsp_shape_value(rsp_shape_value),
      .rsp_deriv_xi   (rsp_deriv_xi),
      .rsp_deriv_eta  (rsp_deriv_eta),
      .rsp_last_node  (rsp_last_node)
   );

   always #1 clock = ~clock;

   // divide by 2^k, rounding toward zero
   function automatic longint scale_down(input longint v, input int k);
      return v / (longint'(1) << k);
   endfunction

   function automatic q8sf_pkg::field_type clamp_field(input longint v);
      if (v > q8sf_pkg::SAT_MAX) return q8sf_pkg::field_type'(q8sf_pkg::SAT_MAX);
      if (v < q8sf_pkg::SAT_MIN) return q8sf_pkg::field_type'(q8sf_pkg::SAT_MIN);
      return q8sf_pkg::field_type'(v);
   endfunction

   // shape values and partials of all eight nodes, queued in node order
   function automatic void predict_shape_nodes(input q8sf_pkg::field_type xi,
                                               input q8sf_pkg::field_type eta,
                                               input logic has_pin,
                                               input logic [7:0][15:0] pin);
      longint          one, x, e, xm, xp, em, ep, sxx, see;
      longint          nv [8];
      longint          ndx [8];
      longint          nde [8];
      node_result_type r;
      one = longint'(1) << FRAC;
      x   = xi;
      e   = eta;
      xm  = one - x;
      xp  = one + x;
      em  = one - e;
      ep  = one + e;
      sxx = scale_down(one * one - x * x, FRAC);
      see = scale_down(one * one - e * e, FRAC);
      // corners
      nv[0]  = scale_down(scale_down(xm * em, FRAC) * (-x - e - one), FRAC + 2);
      ndx[0] = scale_down(em * (2 * x + e), FRAC + 2);
      nde[0] = scale_down(xm * (x + 2 * e), FRAC + 2);
      nv[1]  = scale_down(scale_down(xp * em, FRAC) * (x - e - one), FRAC + 2);
      ndx[1] = scale_down(em * (2 * x - e), FRAC + 2);
      nde[1] = scale_down(xp * (2 * e - x), FRAC + 2);
      nv[2]  = scale_down(scale_down(xp * ep, FRAC) * (x + e - one), FRAC + 2);
      ndx[2] = scale_down(ep * (2 * x + e), FRAC + 2);
      nde[2] = scale_down(xp * (x + 2 * e), FRAC + 2);
      nv[3]  = scale_down(scale_down(xm * ep, FRAC) * (-x + e - one), FRAC + 2);
      ndx[3] = scale_down(ep * (2 * x - e), FRAC + 2);
      nde[3] = scale_down(xm * (2 * e - x), FRAC + 2);
      // midsides
      nv[4]  = scale_down(sxx * em, FRAC + 1);
      ndx[4] = scale_down(x * (e - one), FRAC);
      nde[4] = scale_down(-sxx, 1);
      nv[5]  = scale_down(xp * see, FRAC + 1);
      ndx[5] = scale_down(see, 1);
      nde[5] = scale_down(-(xp * e), FRAC);
      nv[6]  = scale_down(sxx * ep, FRAC + 1);
      ndx[6] = scale_down(-(x * ep), FRAC);
      nde[6] = scale_down(sxx, 1);
      nv[7]  = scale_down(xm * see, FRAC + 1);
      ndx[7] = scale_down(-see, 1);
      nde[7] = scale_down((x - one) * e, FRAC);
      for (int k = 0; k < 8; k++) begin
         r.node  = q8sf_pkg::node_type'(k);
         r.shape = has_pin ? q8sf_pkg::field_type'(pin[k]) : clamp_field(nv[k]);
         r.dxi   = clamp_field(ndx[k]);
         r.deta  = clamp_field(nde[k]);
         r.last  = (r.node == q8sf_pkg::NODE_MID_W);
         node_expect_q.push_back(r);
      end
   endfunction

   // mostly inside the element, some node-point values, some anywhere
   function automatic q8sf_pkg::field_type pick_coord();
      q8sf_pkg::field_type coord_edges [9] = '{-16'sd16384, -16'sd16383, -16'sd1, 16'sd0,
                                               16'sd1, 16'sd16383, 16'sd16384, 16'sh8000,
                                               16'sd32767};
      unique case ($urandom_range(0, 9))
         0: begin
            return q8sf_pkg::field_type'($urandom);
         end
         1: begin
            return coord_edges[$urandom_range(0, 8)];
         end
         default: begin
            return q8sf_pkg::field_type'(int'($urandom_range(0, 32768)) - 16384);
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (mismatch_count < MAX_PRINTS) begin
         $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
      end
      mismatch_count++;
   endtask

   // offer one request after a random gap and hold it until taken
   task automatic send_request(input q8sf_pkg::field_type xi, input q8sf_pkg::field_type eta);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_xi_coord  <= xi;
      req_eta_coord <= eta;
      do @(posedge clock); while (!req_ready);
   endtask

   // request side: reset, directed table, random coordinates, drain
   initial begin : req_side
      q8sf_pkg::field_type xi;
      q8sf_pkg::field_type eta;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (DIR_ROWS[i]) begin
         send_request(DIR_ROWS[i].xi, DIR_ROWS[i].eta);
         predict_shape_nodes(DIR_ROWS[i].xi, DIR_ROWS[i].eta, DIR_ROWS[i].has_pin,
                             DIR_ROWS[i].pin);
      end
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 25 == 0) req_gaps_on = ($urandom_range(0, 3) != 0);
         xi  = pick_coord();
         eta = pick_coord();
         send_request(xi, eta);
         predict_shape_nodes(xi, eta, 1'b0, '0);
      end
      req_valid <= 1'b0;
      while (node_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   // response side: random stalls, one long hold-off to back up the pipeline
   initial begin : rsp_side
      int gap;
      int taken;
      bit gaps_on;
      taken   = 0;
      gaps_on = 1'b1;
      while (reset) @(posedge clock);
      forever begin
         if (taken % 30 == 0) gaps_on = ($urandom_range(0, 3) != 0);
         if (taken == HOLD_AT) gap = HOLD_CYCLES;
         else gap = gaps_on ? $urandom_range(0, 14) : 0;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   // compare each response with the oldest queued node
   always @(posedge clock) begin
      node_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (node_expect_q.size() == 0) begin
            report_mismatch("response with nothing queued, node", rsp_node_index, 0);
         end else begin
            want = node_expect_q.pop_front();
            if (rsp_node_index !== want.node)
               report_mismatch("node_index", rsp_node_index, want.node);
            if (rsp_shape_value !== want.shape)
               report_mismatch($sformatf("node %0d shape_value", want.node),
                               rsp_shape_value, want.shape);
            if (rsp_deriv_xi !== want.dxi)
               report_mismatch($sformatf("node %0d deriv_xi", want.node),
                               rsp_deriv_xi, want.dxi);
            if (rsp_deriv_eta !== want.deta)
               report_mismatch($sformatf("node %0d deriv_eta", want.node),
                               rsp_deriv_eta, want.deta);
            if (rsp_last_node !== want.last)
               report_mismatch($sformatf("node %0d last_node", want.node),
                               rsp_last_node, want.last);
         end
      end
   end

   // watchdog on cycles with no request or response taken
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

endmodule

FILE: files.f
+incdir+design
design/q8sf_pkg.sv
design/q8sf_issue.sv
design/q8sf_term.sv
design/q8sf_final.sv
design/quad8_shape_function_eval.sv
tb/tb_top.sv
